[sv/ulc_pkg.sv]
// Shared types and constants of the UTF-8 to Latin-1 converter.
package ulc_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] LEAD_C2    = 8'hC2;
  localparam logic [7:0] LEAD_C3    = 8'hC3;
  localparam logic [7:0] C3_OFFSET  = 8'h40;
  localparam logic [7:0] SUBST_CHAR = 8'h3F;
  localparam logic [7:0] LIMIT_RST  = 8'hFF;

  // One result item.
  typedef struct packed {
    logic       eos;
    logic       valid;
    logic [7:0] chr;
  } res_t;

  // Results produced by one input byte, handed to the output queue.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

[sv/ulc_step.sv]
// Per-byte decode step and string state of the converter.
module ulc_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic [7:0]    out_limit,
  output ulc_pkg::push_t push
);
  import ulc_pkg::*;

  typedef enum logic [1:0] {PEND_NONE, PEND_C2, PEND_C3} pend_t;

  pend_t      pend, pend_next;
  logic       skip, skip_next;
  logic [7:0] cnt, cnt_next;

  logic       is_cont;
  logic       do_plain;
  logic       pe;
  logic [7:0] pc;
  logic [1:0] n;
  logic [7:0] c0, c1;

  assign is_cont = (in_byte[7:6] == 2'b10);

  always_comb begin
    pend_next = pend;
    skip_next = skip;
    cnt_next  = cnt;
    do_plain  = 1'b0;
    pe        = 1'b0;
    pc        = SUBST_CHAR;
    n         = 2'd0;
    c0        = 8'h00;
    c1        = 8'h00;

    if (pend != PEND_NONE) begin
      pend_next = PEND_NONE;
      if (is_cont) begin
        if (cnt_next < out_limit) begin
          c0       = (pend == PEND_C2) ? in_byte : 8'(in_byte + C3_OFFSET);
          n        = 2'd1;
          cnt_next = 8'(cnt_next + 8'd1);
        end
      end else begin
        if (cnt_next < out_limit) begin
          c0       = SUBST_CHAR;
          n        = 2'd1;
          cnt_next = 8'(cnt_next + 8'd1);
        end
        do_plain = 1'b1;
      end
    end else if (skip) begin
      if (!is_cont) begin
        skip_next = 1'b0;
        do_plain  = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    // Plain byte handling, only while room is left.
    if (do_plain && (cnt_next < out_limit)) begin
      if (in_byte < ASCII_TOP) begin
        pe = 1'b1;
        pc = in_byte;
      end else if (in_byte == LEAD_C2 || in_byte == LEAD_C3) begin
        if (in_last) begin
          pe = 1'b1;
        end else begin
          pend_next = (in_byte == LEAD_C2) ? PEND_C2 : PEND_C3;
        end
      end else begin
        pe        = 1'b1;
        skip_next = 1'b1;
      end
      if (pe) begin
        if (n == 2'd0) begin
          c0 = pc;
        end else begin
          c1 = pc;
        end
        n        = 2'(n + 2'd1);
        cnt_next = 8'(cnt_next + 8'd1);
      end
    end

    push.r0 = '{eos: 1'b0, valid: 1'b1, chr: c0};
    push.r1 = '{eos: 1'b0, valid: 1'b1, chr: c1};
    push.num = n;
    if (in_last) begin
      if (n == 2'd0) begin
        push.num = 2'd1;
        push.r0  = '{eos: 1'b1, valid: 1'b0, chr: 8'h00};
      end else if (n == 2'd1) begin
        push.r0.eos = 1'b1;
      end else begin
        push.r1.eos = 1'b1;
      end
      pend_next = PEND_NONE;
      skip_next = 1'b0;
      cnt_next  = 8'h00;
    end
    if (!advance) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= PEND_NONE;
      skip <= 1'b0;
      cnt  <= 8'h00;
    end else if (advance) begin
      pend <= pend_next;
      skip <= skip_next;
      cnt  <= cnt_next;
    end
  end

endmodule

[sv/ulc_out_fifo.sv]
// Result queue: takes up to two results a cycle, hands out one while the receiver is ready.
module ulc_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  ulc_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output ulc_pkg::res_t  out_res
);
  import ulc_pkg::*;

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for a full pair of results, judged on registered state only.
  assign room      = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[PTR_W'(wr_ptr + PTR_W'(1))] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push.num));
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + PTR_W'(1));
      end
      count <= CNT_W'(count + CNT_W'(push.num) - CNT_W'(pop));
    end
  end

endmodule

[sv/utf8_to_latin1_converter.sv]
// Top level of the UTF-8 to Latin-1 stream converter.
//
//   channel  direction  payload
//   s_*      in         tdata[7:0] in_byte, tlast in_last
//   m_*      out        tdata[7:0] out_char, tuser char_valid, tlast end_of_string
//   cfg_*    in         cfg_wdata[7:0] out_limit (write on cfg_wen)
//
// One byte is taken per cycle while the queue has room. A byte is held in the
// input register, then its results (none, one or two) enter a four-entry result
// queue and leave it one at a time; a held byte waits, and the input stalls
// behind it, while the queue holds more than two results. Synchronous reset
// empties both stages, clears the string state and sets out_limit to 255.
module utf8_to_latin1_converter (
  input  logic       clk,
  input  logic       rst,
  // write port for out_limit
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tuser,   // [0] char_valid
  output logic       m_tlast    // end_of_string
);
  import ulc_pkg::*;

  logic [7:0] out_limit;

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  logic       room;
  logic       advance;
  push_t      push;
  res_t       out_res;

  // Advance the held byte whenever the queue can take a pair of results.
  assign advance  = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= LIMIT_RST;
    end else if (cfg_wen) begin
      out_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Payload needs no reset; load on every accepted request.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  ulc_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_limit (out_limit),
    .push      (push)
  );

  ulc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.chr;
  assign m_tuser = out_res.valid;
  assign m_tlast = out_res.eos;

endmodule

[sv/ulc_checker.sv]
// Port-level checks for the converter, bound to its top level.
module ulc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // Reset leaves the input side open.
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  // A result without a character is always the bare end marker.
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 8'h00))
    else $error("empty result that is not an end marker");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind utf8_to_latin1_converter ulc_checker u_ulc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[bench/tb.sv]
// Self-checking bench for the UTF-8 to Latin-1 stream converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ulc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [7:0]  CONT_TOP    = 8'hBF;
  localparam logic [7:0]  LIMIT_NONE  = 8'h00;
  localparam int          SETTLE      = 8;

  // Lead byte waiting for its continuation byte.
  typedef enum logic [1:0] {
    LEAD_NONE,
    LEAD_C2_WAIT,
    LEAD_C3_WAIT
  } lead_e;

  // One byte request of the input stream.
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } byte_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wen = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  utf8_to_latin1_converter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Byte requests waiting to be driven, filled by the sequence below.
  byte_req_t   bytes_to_send[$];
  // String under construction before it is handed to the driver.
  logic [7:0]  str_buf[$];
  // Latin-1 results still owed by the converter, oldest first.
  res_t        expected_chars[$];
  // Results caused by the byte being transcoded right now.
  res_t        step_chars[$];

  // Predictor copy of the converter's string state and register.
  lead_e       lead_wait = LEAD_NONE;
  logic        dropping_cont = 1'b0;
  logic [7:0]  chars_out = 8'h00;
  logic [7:0]  limit_now = LIMIT_RST;

  int unsigned cycles = 0;
  int          errors = 0;
  int          queued_total = 0;
  int          bytes_taken = 0;
  int          strings_taken = 0;
  int          chars_checked = 0;
  int          idle_pct = 25;
  int          send_gap = 0;
  int          recv_stall = 0;
  logic        req_taken = 1'b0;
  byte_req_t   next_req;
  res_t        want;
  logic [7:0]  mid_limit;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_cont(input logic [7:0] b);
    return b >= ASCII_TOP && b <= CONT_TOP;
  endfunction

  // Emit one character while the string still has room; at most two per byte.
  function automatic void emit_char(input logic [7:0] c);
    if (chars_out < limit_now && step_chars.size() < 2) begin
      step_chars.push_back('{eos: 1'b0, valid: 1'b1, chr: c});
      chars_out = chars_out + 8'd1;
    end
  endfunction

  // Byte seen with no lead waiting and no continuation bytes being dropped.
  function automatic void take_plain(input logic [7:0] b, input logic last);
    if (chars_out >= limit_now)
      return;
    if (b < ASCII_TOP) begin
      emit_char(b);
    end else if (b == LEAD_C2 || b == LEAD_C3) begin
      // a lead on the final byte can never be completed
      if (last)
        emit_char(SUBST_CHAR);
      else
        lead_wait = (b == LEAD_C2) ? LEAD_C2_WAIT : LEAD_C3_WAIT;
    end else begin
      emit_char(SUBST_CHAR);
      dropping_cont = 1'b1;
    end
  endfunction

  // Advance the string state by one accepted byte and queue its results.
  function automatic void transcode_byte(input logic [7:0] b, input logic last);
    lead_e lead;
    lead = lead_wait;
    step_chars.delete();
    if (lead != LEAD_NONE) begin
      lead_wait = LEAD_NONE;
      if (is_cont(b)) begin
        emit_char(lead == LEAD_C2_WAIT ? b : b + C3_OFFSET);
      end else begin
        // broken lead: substitute it, then treat this byte on its own
        emit_char(SUBST_CHAR);
        take_plain(b, last);
      end
    end else if (dropping_cont) begin
      if (!is_cont(b)) begin
        dropping_cont = 1'b0;
        take_plain(b, last);
      end
    end else begin
      take_plain(b, last);
    end
    if (last) begin
      // tag the final result, or send a bare end marker if nothing is left
      if (step_chars.size() == 0)
        step_chars.push_back('{eos: 1'b1, valid: 1'b0, chr: 8'h00});
      else
        step_chars[step_chars.size() - 1].eos = 1'b1;
      lead_wait     = LEAD_NONE;
      dropping_cont = 1'b0;
      chars_out     = 8'h00;
    end
    foreach (step_chars[i])
      expected_chars.push_back(step_chars[i]);
  endfunction

  function automatic void check_field(input string what, input logic [7:0] exp_v,
                                      input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, got_v);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      // Hold the current request until the converter takes it.
      if (!s_tvalid || req_taken) begin
        if (send_gap > 0) begin
          s_tvalid <= 1'b0;
          send_gap--;
        end else if (bytes_to_send.size() > 0) begin
          next_req = bytes_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_req.b;
          s_tlast  <= next_req.last;
          // schedule a burst of idle cycles before the following request
          if ($urandom_range(0, 99) < idle_pct)
            send_gap = $urandom_range(1, 5);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      // Stall the result side in random bursts.
      if (recv_stall > 0) begin
        m_tready <= 1'b0;
        recv_stall--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 99) < idle_pct)
          recv_stall = $urandom_range(1, 5);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      req_taken <= s_tvalid && s_tready && !rst;
      if (!rst) begin
        // Compare each result with the oldest owed character.
        if (m_tvalid && m_tready) begin
          if (expected_chars.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual chr %h valid %b eos %b",
                     $time, m_tdata, m_tuser, m_tlast);
            errors++;
          end else begin
            want = expected_chars.pop_front();
            check_field("out_char", want.chr, m_tdata);
            check_field("char_valid", {7'd0, want.valid}, {7'd0, m_tuser});
            check_field("end_of_string", {7'd0, want.eos}, {7'd0, m_tlast});
            chars_checked++;
          end
        end
        // Predict the results of every accepted byte request.
        if (s_tvalid && s_tready) begin
          transcode_byte(s_tdata, s_tlast);
          bytes_taken++;
          if (s_tlast)
            strings_taken++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mark the end of the buffered string and hand it to the driver.
  task automatic commit_string();
    foreach (str_buf[i])
      bytes_to_send.push_back('{b: str_buf[i], last: i == str_buf.size() - 1});
    queued_total += str_buf.size();
    str_buf.delete();
  endtask

  function automatic logic [7:0] rand_cont();
    return ASCII_TOP | 8'($urandom_range(0, 63));
  endfunction

  // Append one character: mostly well-formed UTF-8, some broken or noise bytes.
  task automatic add_random_char();
    int pick;
    int n_cont;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      str_buf.push_back(8'($urandom_range(1, 127)));
    end else if (pick < 55) begin
      str_buf.push_back(LEAD_C2);
      str_buf.push_back(rand_cont());
    end else if (pick < 70) begin
      str_buf.push_back(LEAD_C3);
      str_buf.push_back(rand_cont());
    end else if (pick < 78) begin
      // other two- and three-byte sequences, all outside Latin-1
      str_buf.push_back(8'($urandom_range(8'hC4, 8'hEF)));
      n_cont = $urandom_range(1, 2);
      repeat (n_cont) str_buf.push_back(rand_cont());
    end else if (pick < 83) begin
      str_buf.push_back(8'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) str_buf.push_back(rand_cont());
    end else if (pick < 88) begin
      // lead left dangling; a following continuation byte may still complete it
      str_buf.push_back($urandom_range(0, 1) ? LEAD_C2 : LEAD_C3);
    end else if (pick < 93) begin
      str_buf.push_back(rand_cont());
    end else begin
      str_buf.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // Queue random strings of 1..max_chars characters until n_bytes are queued.
  task automatic add_strings(input int n_bytes, input int max_chars);
    int start;
    int n;
    start = queued_total;
    while (queued_total - start < n_bytes) begin
      n = $urandom_range(1, max_chars);
      repeat (n) add_random_char();
      commit_string();
    end
  endtask

  // Wait until no request is pending and every owed result has arrived.
  task automatic drain();
    while (bytes_to_send.size() > 0 || s_tvalid || expected_chars.size() > 0)
      @(posedge clk);
    // let bytes that cause no result clear the pipeline
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    limit_now = v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings at the reset limit: pass-through extremes, both leads
    // with the lowest and highest continuation, broken leads, dropped
    // continuations, a zero byte and leads on the final byte.
    str_buf = '{8'h01, 8'h7F, 8'hC2, 8'h80, 8'hC2, 8'hBF, 8'hC3, 8'h80, 8'hC3, 8'hBF};
    commit_string();
    str_buf = '{8'hC2, 8'h41, 8'hC3, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h41, 8'h80,
                8'hFF, 8'h00};
    commit_string();
    str_buf = '{8'hE9, 8'h80};
    commit_string();
    str_buf = '{8'hC2, 8'hC3};
    commit_string();
    str_buf = '{8'hC3};
    commit_string();

    // Smallest nonzero limit: most strings hit it at once.
    idle_pct = 30;
    set_limit(8'd1);
    add_strings(40, 4);

    idle_pct = 15;
    set_limit(8'd3);
    add_strings(50, 8);

    idle_pct = 40;
    mid_limit = 8'($urandom_range(4, 40));
    set_limit(mid_limit);
    add_strings(70, 20);

    // No room at all: every string reduces to its end marker.
    idle_pct = 20;
    set_limit(LIMIT_NONE);
    add_strings(15, 3);

    // Largest limit with no idling: run one string past 255 characters.
    set_limit(LIMIT_RST);
    idle_pct = 0;
    repeat (258) str_buf.push_back(8'($urandom_range(1, 127)));
    str_buf.push_back(LEAD_C3);
    str_buf.push_back(8'hA9);
    commit_string();
    add_strings(50, 12);

    drain();
    $display("Sent %0d bytes in %0d strings, checked %0d results", bytes_taken,
             strings_taken, chars_checked);
    $display("Limits exercised: 255, 1, 3, %0d, 0 and 255 again", mid_limit);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
